### rtl/mrfc_pkg.sv
// Shared types and constants for the rangefinder frame collector.
// No dependencies; every other file imports this package.
package mrfc_pkg;

	// Fixed field widths and sizes
	localparam int MAX_SENSORS = 5;
	localparam int MNT_IDX_W   = 3;
	localparam int MOUNT_W     = 48;
	localparam int DIST_W      = 16;
	localparam int CHAN_W      = 3;
	localparam int BYTE_W      = 8;
	localparam int S_TDATA_W   = 16;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 6;
	localparam int REG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int PKT_IDX_W   = 4;

	// Frame bytes
	localparam logic [7:0] RF_HEADER  = 8'h5C;
	localparam logic [7:0] PKT_HEADER = 8'hCC;
	localparam logic [7:0] PKT_FOOTER = 8'h55;

	// Packet byte positions
	localparam logic [PKT_IDX_W-1:0] PKT_HDR  = 4'd0;
	localparam logic [PKT_IDX_W-1:0] PKT_CHAN = 4'd1;
	localparam logic [PKT_IDX_W-1:0] PKT_DLO  = 4'd2;
	localparam logic [PKT_IDX_W-1:0] PKT_DHI  = 4'd3;
	localparam logic [PKT_IDX_W-1:0] PKT_MNT0 = 4'd4;
	localparam logic [PKT_IDX_W-1:0] PKT_MNT1 = 4'd5;
	localparam logic [PKT_IDX_W-1:0] PKT_MNT2 = 4'd6;
	localparam logic [PKT_IDX_W-1:0] PKT_MNT3 = 4'd7;
	localparam logic [PKT_IDX_W-1:0] PKT_MNT4 = 4'd8;
	localparam logic [PKT_IDX_W-1:0] PKT_MNT5 = 4'd9;
	localparam logic [PKT_IDX_W-1:0] PKT_XOR  = 4'd10;
	localparam logic [PKT_IDX_W-1:0] PKT_FTR  = 4'd11;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_MIN_DIST = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_OOR_DIST = 3'd6;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_POLL = 1'b1
	} cmd_kind_t;

	typedef enum logic [1:0] {
		FP_WAIT_HDR = 2'd0,
		FP_DIST_LO  = 2'd1,
		FP_DIST_HI  = 2'd2,
		FP_CHECK    = 2'd3
	} frame_pos_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_EMIT = 1'b1
	} bk_state_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [CHAN_W-1:0]  channel;
		logic [BYTE_W-1:0]  data;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### rtl/mrfc_front.sv
// Front end: accepts input beats, drops bytes from absent links and
// forms queue commands. Depends on mrfc_pkg.
module mrfc_front #(
	parameter int NUM_SENSORS = 5
) (
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mrfc_pkg::S_TDATA_W-1:0]      s_tdata,  // [2:0] channel, [10:3] rx_byte
	input  logic                                s_tuser,  // [0] func
	input  mrfc_pkg::q_stat_t                   q_stat,
	output logic                                push,
	output mrfc_pkg::cmd_t                      cmd
);
	import mrfc_pkg::*;

	logic accept;
	logic keep;

	// Take a beat whenever the queue has room
	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	// Classify the beat
	always_comb begin
		cmd.kind    = cmd_kind_t'(s_tuser);
		cmd.channel = s_tdata[CHAN_W-1:0];
		cmd.data    = s_tdata[CHAN_W +: BYTE_W];
	end

	// Drop bytes of links that do not exist
	assign keep = (cmd.kind == CMD_POLL) || (cmd.channel < CHAN_W'(NUM_SENSORS));
	assign push = accept && keep;

endmodule

### rtl/mrfc_fifo.sv
// Short command queue between the front and back ends.
// Depends on mrfc_pkg for the command and status types.
module mrfc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mrfc_pkg::cmd_t    wr_cmd,
	input  logic              pop,
	output mrfc_pkg::cmd_t    rd_cmd,
	output mrfc_pkg::q_stat_t stat
);
	import mrfc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_cmd     = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full) else $error("push into full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of bounds");

endmodule

### rtl/mrfc_back.sv
// Back end: per-link frame parsers and the packet emitter with its
// output register. Depends on mrfc_pkg.
module mrfc_back #(
	parameter int NUM_SENSORS = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mrfc_pkg::cmd_t                    q_cmd,
	input  mrfc_pkg::q_stat_t                 q_stat,
	output logic                              pop,
	input  logic [mrfc_pkg::MOUNT_W-1:0]      mount_words [mrfc_pkg::MAX_SENSORS],
	input  logic [mrfc_pkg::DIST_W-1:0]       min_dist,
	input  logic [mrfc_pkg::DIST_W-1:0]       oor_dist,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mrfc_pkg::BYTE_W-1:0]       m_tdata,  // [7:0] out_byte
	output logic                              m_tlast   // last
);
	import mrfc_pkg::*;

	localparam int CH_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

	function automatic logic [CH_W-1:0] lowest_set(input logic [NUM_SENSORS-1:0] m);
		logic [CH_W-1:0] r;
		r = '0;
		for (int i = NUM_SENSORS - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = CH_W'(i);
			end
		end
		return r;
	endfunction

	// Per-link state
	frame_pos_t              pos_q   [NUM_SENSORS];
	logic [DIST_W-1:0]       part_q  [NUM_SENSORS];
	logic [DIST_W-1:0]       dist_q  [NUM_SENSORS];
	logic [NUM_SENSORS-1:0]  fresh_q;

	// Emitter state
	bk_state_t               state_q, state_d;
	logic [CH_W-1:0]         ch_q;
	logic [NUM_SENSORS-1:0]  mask_q;
	logic [PKT_IDX_W-1:0]    idx_q;
	logic [BYTE_W-1:0]       xor_q;

	// Output register
	logic                    m_tvalid_q;
	logic [BYTE_W-1:0]       m_tdata_q;
	logic                    m_tlast_q;

	logic                    out_free;
	logic                    take_byte;
	logic                    take_poll;
	logic [CH_W-1:0]         rx_ch;
	frame_pos_t              rx_pos;
	logic [DIST_W-1:0]       rx_part;
	logic [BYTE_W-1:0]       rx_chk;
	logic                    rx_good;
	logic [CH_W-1:0]         first_ch;
	logic [CH_W-1:0]         next_ch;
	logic [MOUNT_W-1:0]      mount_sel;
	logic [DIST_W-1:0]       dist_sel;
	logic [BYTE_W-1:0]       cur_byte;
	logic                    pkt_end;
	logic                    in_xor;

	assign out_free  = !m_tvalid_q || m_tready;
	assign take_byte = pop && (q_cmd.kind == CMD_BYTE);
	assign take_poll = pop && (q_cmd.kind == CMD_POLL);

	// Parser lookup for the addressed link
	assign rx_ch   = CH_W'(q_cmd.channel);
	assign rx_pos  = pos_q[rx_ch];
	assign rx_part = part_q[rx_ch];
	assign rx_chk  = ~(rx_part[7:0] + rx_part[15:8]);
	assign rx_good = (rx_chk == q_cmd.data) && (rx_part >= min_dist) && (rx_part < oor_dist);

	// Packet byte selection
	assign first_ch  = lowest_set(fresh_q);
	assign next_ch   = lowest_set(mask_q);
	assign mount_sel = mount_words[MNT_IDX_W'(ch_q)];
	assign dist_sel  = dist_q[ch_q];
	assign pkt_end   = (idx_q == PKT_FTR);
	assign in_xor    = (idx_q >= PKT_CHAN) && (idx_q <= PKT_MNT5);

	always_comb begin
		unique case (idx_q)
			PKT_HDR:  cur_byte = PKT_HEADER;
			PKT_CHAN: cur_byte = BYTE_W'(ch_q);
			PKT_DLO:  cur_byte = dist_sel[7:0];
			PKT_DHI:  cur_byte = dist_sel[15:8];
			PKT_MNT0: cur_byte = mount_sel[7:0];
			PKT_MNT1: cur_byte = mount_sel[15:8];
			PKT_MNT2: cur_byte = mount_sel[23:16];
			PKT_MNT3: cur_byte = mount_sel[31:24];
			PKT_MNT4: cur_byte = mount_sel[39:32];
			PKT_MNT5: cur_byte = mount_sel[47:40];
			PKT_XOR:  cur_byte = xor_q;
			PKT_FTR:  cur_byte = PKT_FOOTER;
			default:  cur_byte = '0;
		endcase
	end

	// Next state and queue pop
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					if ((q_cmd.kind == CMD_POLL) && (fresh_q != '0)) begin
						state_d = BK_EMIT;
					end
				end
			end
			BK_EMIT: begin
				if (out_free && pkt_end && (mask_q == '0)) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Collect distance bytes
	always_ff @(posedge clk) begin
		if (take_byte) begin
			if (rx_pos == FP_DIST_LO) begin
				part_q[rx_ch][7:0] <= q_cmd.data;
			end else if (rx_pos == FP_DIST_HI) begin
				part_q[rx_ch][15:8] <= q_cmd.data;
			end
		end
	end

	// Advance parsers, store good distances, clear fresh flags on poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				pos_q[i]  <= FP_WAIT_HDR;
				dist_q[i] <= '0;
			end
			fresh_q <= '0;
		end else if (take_poll) begin
			fresh_q <= '0;
		end else if (take_byte) begin
			unique case (rx_pos)
				FP_WAIT_HDR: begin
					if (q_cmd.data == RF_HEADER) begin
						pos_q[rx_ch] <= FP_DIST_LO;
					end
				end
				FP_DIST_LO: pos_q[rx_ch] <= FP_DIST_HI;
				FP_DIST_HI: pos_q[rx_ch] <= FP_CHECK;
				FP_CHECK: begin
					pos_q[rx_ch] <= FP_WAIT_HDR;
					if (rx_good) begin
						dist_q[rx_ch]  <= rx_part;
						fresh_q[rx_ch] <= 1'b1;
					end
				end
				default: pos_q[rx_ch] <= FP_WAIT_HDR;
			endcase
		end
	end

	// Walk fresh links and packet bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q   <= '0;
			mask_q <= '0;
			idx_q  <= '0;
			xor_q  <= '0;
		end else if ((state_q == BK_IDLE) && take_poll) begin
			ch_q   <= first_ch;
			mask_q <= fresh_q & ~(NUM_SENSORS'(1) << first_ch);
			idx_q  <= PKT_HDR;
			xor_q  <= '0;
		end else if ((state_q == BK_EMIT) && out_free) begin
			if (pkt_end) begin
				ch_q   <= next_ch;
				mask_q <= mask_q & ~(NUM_SENSORS'(1) << next_ch);
				idx_q  <= PKT_HDR;
				xor_q  <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
				if (in_xor) begin
					xor_q <= xor_q ^ cur_byte;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else if ((state_q == BK_EMIT) && out_free) begin
			m_tvalid_q <= 1'b1;
			m_tdata_q  <= cur_byte;
			m_tlast_q  <= pkt_end && (mask_q == '0);
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT) |-> (idx_q <= PKT_FTR)) else $error("packet index overrun");

	a_cur_not_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT) |-> !mask_q[ch_q]) else $error("current link still pending");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty) else $error("pop from empty queue");

endmodule

### rtl/multi_rangefinder_frame_collector_core.sv
// A received byte is parsed when the idle back end pops it; a poll emits a 12-byte packet
// per fresh link, one packet byte per cycle through the output register while the receiver
// is ready, and the queue is not popped meanwhile. A beat enters the command queue at
// acceptance; a poll's first byte then passes the emitter state and the output register.
// Reset (arst_n low): parsers wait for a header, nothing is fresh, distances are zero,
// mount words and min distance clear, out-of-range distance goes to 0xFFFF.
module multi_rangefinder_frame_collector_core #(
	parameter int NUM_SENSORS = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mrfc_pkg::S_TDATA_W-1:0]      s_tdata,   // [2:0] channel, [10:3] rx_byte
	input  logic                                s_tuser,   // [0] func
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mrfc_pkg::BYTE_W-1:0]         m_tdata,   // [7:0] out_byte
	output logic                                m_tlast,   // last
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mrfc_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [mrfc_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [mrfc_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import mrfc_pkg::*;

	logic [MOUNT_W-1:0]   mount_q [MAX_SENSORS];
	logic [DIST_W-1:0]    min_dist_q;
	logic [DIST_W-1:0]    oor_dist_q;
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	logic                 push;
	logic                 pop;
	cmd_t                 wr_cmd;
	cmd_t                 rd_cmd;
	q_stat_t              q_stat;

	// Register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SENSORS; i++) begin
				mount_q[i] <= '0;
			end
			min_dist_q <= '0;
			oor_dist_q <= '1;
		end else if (cfg_wr) begin
			if (reg_idx < REG_IDX_W'(MAX_SENSORS)) begin
				mount_q[reg_idx] <= pwdata[MOUNT_W-1:0];
			end else if (reg_idx == REG_MIN_DIST) begin
				min_dist_q <= pwdata[DIST_W-1:0];
			end else if (reg_idx == REG_OOR_DIST) begin
				oor_dist_q <= pwdata[DIST_W-1:0];
			end
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (reg_idx < REG_IDX_W'(MAX_SENSORS)) begin
			prdata = CFG_DATA_W'(mount_q[reg_idx]);
		end else if (reg_idx == REG_MIN_DIST) begin
			prdata = CFG_DATA_W'(min_dist_q);
		end else if (reg_idx == REG_OOR_DIST) begin
			prdata = CFG_DATA_W'(oor_dist_q);
		end
	end

	mrfc_front #(
		.NUM_SENSORS (NUM_SENSORS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.cmd      (wr_cmd)
	);

	mrfc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.stat   (q_stat)
	);

	mrfc_back #(
		.NUM_SENSORS (NUM_SENSORS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_cmd       (rd_cmd),
		.q_stat      (q_stat),
		.pop         (pop),
		.mount_words (mount_q),
		.min_dist    (min_dist_q),
		.oor_dist    (oor_dist_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule

### sim/multi_rangefinder_frame_collector_core_test.sv
// Self-checking bench for the multi-link rangefinder frame collector core.
// Drives link bytes and polls, writes the mount and window registers, and checks packet bytes.
// Needs mrfc_pkg and multi_rangefinder_frame_collector_core.
module multi_rangefinder_frame_collector_core_test;
	import mrfc_pkg::*;

	localparam int NUM_LINKS   = 5;
	localparam int HOLD_LEN    = 400;
	localparam int SETTLE_CYC  = 16;
	localparam int MAX_PRINTS  = 40;

	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              last;
	} pkt_byte_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;   // [2:0] channel, [10:3] rx_byte
	logic                   s_tuser = 1'b0; // [0] func
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [BYTE_W-1:0]      m_tdata;        // [7:0] out_byte
	logic                   m_tlast;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0]  paddr = '0;
	logic [CFG_DATA_W-1:0]  pwdata = '0;
	logic [CFG_DATA_W-1:0]  prdata;
	logic                   pready;

	// Stimulus and expectation stores
	cmd_t       pending_cmds[$];
	pkt_byte_t  packet_bytes_due[$];
	cmd_t       cur_cmd;
	int         mismatches = 0;
	logic       no_idle = 1'b0;
	logic       hold_req = 1'b0;

	// Shadow copy of the block's registers and per-link state
	logic [MOUNT_W-1:0] mount_regs [NUM_LINKS];
	logic [DIST_W-1:0]  min_dist;
	logic [DIST_W-1:0]  oor_dist;
	frame_pos_t         link_pos [NUM_LINKS];
	logic [DIST_W-1:0]  link_partial [NUM_LINKS];
	logic [DIST_W-1:0]  link_dist [NUM_LINKS];
	logic               link_fresh [NUM_LINKS];

	multi_rangefinder_frame_collector_core #(
		.NUM_SENSORS(NUM_LINKS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("multi_rangefinder_frame_collector_core regression: fail");
		$finish;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
	endtask

	// Advance one link's frame parser by one received byte
	task automatic parse_link_byte(input int ch, input logic [BYTE_W-1:0] b);
		logic [DIST_W-1:0] range_mm;
		logic [BYTE_W-1:0] chk;
		case (link_pos[ch])
			FP_WAIT_HDR: begin
				if (b == RF_HEADER)
					link_pos[ch] = FP_DIST_LO;
			end
			FP_DIST_LO: begin
				link_partial[ch][7:0] = b;
				link_pos[ch] = FP_DIST_HI;
			end
			FP_DIST_HI: begin
				link_partial[ch][15:8] = b;
				link_pos[ch] = FP_CHECK;
			end
			default: begin
				range_mm = link_partial[ch];
				chk = range_mm[7:0] + range_mm[15:8];
				chk = ~chk;
				if (chk == b && range_mm >= min_dist && range_mm < oor_dist) begin
					link_dist[ch] = range_mm;
					link_fresh[ch] = 1'b1;
				end
				link_pos[ch] = FP_WAIT_HDR;
			end
		endcase
	endtask

	// Work out the packet bytes that one accepted beat causes
	task automatic predict_packet_bytes(input cmd_t c);
		logic [BYTE_W-1:0] pkt [12];
		logic [BYTE_W-1:0] out_q[$];
		logic [BYTE_W-1:0] x;
		pkt_byte_t         e;
		if (c.kind == CMD_BYTE) begin
			if (c.channel < NUM_LINKS)
				parse_link_byte(int'(c.channel), c.data);
		end else begin
			for (int ch = 0; ch < NUM_LINKS; ch++) begin
				if (link_fresh[ch]) begin
					link_fresh[ch] = 1'b0;
					pkt[0] = PKT_HEADER;
					pkt[1] = 8'(ch);
					pkt[2] = link_dist[ch][7:0];
					pkt[3] = link_dist[ch][15:8];
					for (int k = 0; k < 6; k++)
						pkt[4 + k] = mount_regs[ch][8*k +: 8];
					x = '0;
					for (int k = 1; k <= 9; k++)
						x ^= pkt[k];
					pkt[10] = x;
					pkt[11] = PKT_FOOTER;
					for (int k = 0; k < 12; k++)
						out_q.push_back(pkt[k]);
				end
			end
			for (int i = 0; i < out_q.size(); i++) begin
				e.b = out_q[i];
				e.last = (i == out_q.size() - 1);
				packet_bytes_due.push_back(e);
			end
		end
	endtask

	// Sender: present queued beats, with random gap bursts
	always @(posedge clk or negedge arst_n) begin : drive_proc
		int gap_left;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= CMD_BYTE;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_packet_bytes(cur_cmd);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_cmds.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (!no_idle && $urandom_range(0, 4) == 0) begin
					gap_left = $urandom_range(0, 6);
					s_tvalid <= 1'b0;
				end else begin
					cur_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{(S_TDATA_W - CHAN_W - BYTE_W){1'b0}},
						cur_cmd.data, cur_cmd.channel};
					s_tuser <= cur_cmd.kind;
				end
			end
		end
	end

	// Receiver: check each output beat and drive ready with stalls and the long hold-off
	always @(posedge clk or negedge arst_n) begin : recv_proc
		int        stall_left;
		int        hold_cycles;
		pkt_byte_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			hold_cycles = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (packet_bytes_due.size() == 0) begin
					flag_mismatch("unexpected packet byte", int'(m_tdata), 0);
				end else begin
					e = packet_bytes_due.pop_front();
					if (m_tdata !== e.b)
						flag_mismatch("out_byte", int'(m_tdata), int'(e.b));
					if (m_tlast !== e.last)
						flag_mismatch("last", int'(m_tlast), int'(e.last));
				end
			end
			if (!hold_req)
				hold_cycles = 0;
			if (hold_req && hold_cycles < HOLD_LEN) begin
				hold_cycles++;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 6);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic reg_write(input int idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(idx * 8);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < NUM_LINKS)
			mount_regs[idx] = val[MOUNT_W-1:0];
		else if (idx == REG_MIN_DIST)
			min_dist = val[DIST_W-1:0];
		else if (idx == REG_OOR_DIST)
			oor_dist = val[DIST_W-1:0];
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	task automatic push_cmd(input cmd_kind_t kind, input int ch, input logic [BYTE_W-1:0] b);
		cmd_t c;
		c.kind = kind;
		c.channel = CHAN_W'(ch);
		c.data = b;
		pending_cmds.push_back(c);
	endtask

	task automatic push_poll();
		push_cmd(CMD_POLL, $urandom_range(0, 7), BYTE_W'($urandom_range(0, 255)));
	endtask

	// Queue a whole frame; corrupt one checksum bit when asked
	task automatic push_frame(input int ch, input logic [DIST_W-1:0] range_mm, input logic good);
		logic [BYTE_W-1:0] chk;
		chk = range_mm[7:0] + range_mm[15:8];
		chk = ~chk;
		if (!good)
			chk ^= 8'(1 << $urandom_range(0, 7));
		push_cmd(CMD_BYTE, ch, RF_HEADER);
		push_cmd(CMD_BYTE, ch, range_mm[7:0]);
		push_cmd(CMD_BYTE, ch, range_mm[15:8]);
		push_cmd(CMD_BYTE, ch, chk);
	endtask

	// Favor the window and its edges
	function automatic logic [DIST_W-1:0] pick_distance();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return min_dist;
		if (r == 1)
			return oor_dist - 1'b1;
		if (r == 2)
			return oor_dist;
		if (r == 3 || oor_dist <= min_dist)
			return DIST_W'($urandom());
		return min_dist + DIST_W'($urandom_range(0, int'(oor_dist - min_dist) - 1));
	endfunction

	// Mostly well-formed frames, plus polls, noise bytes and cut-off frames
	task automatic push_random_items(input int count);
		int pushed;
		int r;
		int ch;
		pushed = 0;
		while (pushed < count) begin
			r = $urandom_range(0, 99);
			ch = $urandom_range(0, NUM_LINKS - 1);
			if (r < 68) begin
				push_frame(ch, pick_distance(), $urandom_range(0, 99) < 85);
				pushed += 4;
			end else if (r < 80) begin
				push_poll();
				pushed++;
			end else if (r < 92) begin
				push_cmd(CMD_BYTE, $urandom_range(0, 7), BYTE_W'($urandom_range(0, 255)));
				pushed++;
			end else begin
				push_cmd(CMD_BYTE, ch, RF_HEADER);
				push_cmd(CMD_BYTE, ch, BYTE_W'($urandom_range(0, 255)));
				pushed += 2;
			end
		end
	endtask

	// Hold until every beat is accepted and every packet byte has come out
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || s_tvalid || packet_bytes_due.size() != 0);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	initial begin : stim_proc
		int drain_cyc;
		for (int i = 0; i < NUM_LINKS; i++) begin
			mount_regs[i] = '0;
			link_pos[i] = FP_WAIT_HDR;
			link_partial[i] = '0;
			link_dist[i] = '0;
			link_fresh[i] = 1'b0;
		end
		min_dist = '0;
		oor_dist = 16'hFFFF;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: window edges at reset settings, bad checksum, ignored links
		push_frame(0, 16'h0000, 1'b1);
		push_frame(4, 16'hFFFE, 1'b1);
		push_frame(1, 16'hFFFF, 1'b1);
		push_cmd(CMD_BYTE, 7, RF_HEADER);
		push_cmd(CMD_BYTE, 3, 8'hA7);
		push_frame(2, 16'h1234, 1'b0);
		push_cmd(CMD_BYTE, 5, RF_HEADER);
		push_cmd(CMD_BYTE, 6, 8'hFF);
		push_poll();
		push_poll();
		wait_idle();

		// Mount extremes and a random window, with a sender pause midway
		reg_write(0, '0);
		reg_write(1, {CFG_DATA_W{1'b1}});
		for (int i = 2; i < NUM_LINKS; i++)
			reg_write(i, rand_word());
		reg_write(int'(REG_MIN_DIST), CFG_DATA_W'($urandom_range(0, 16'h3FFF)));
		reg_write(int'(REG_OOR_DIST), CFG_DATA_W'($urandom_range(16'hC000, 16'hFFFF)));
		push_random_items(60);
		push_poll();
		wait_idle();
		push_random_items(50);
		push_poll();
		wait_idle();

		// Empty window at the register extremes: nothing may be stored
		reg_write(int'(REG_MIN_DIST), CFG_DATA_W'(16'hFFFF));
		reg_write(int'(REG_OOR_DIST), CFG_DATA_W'(16'h0000));
		push_random_items(30);
		wait_idle();

		// Full window while the receiver holds off long enough to back up the input
		reg_write(int'(REG_MIN_DIST), CFG_DATA_W'(16'h0000));
		reg_write(int'(REG_OOR_DIST), CFG_DATA_W'(16'hFFFF));
		for (int i = 0; i < NUM_LINKS; i++)
			reg_write(i, rand_word());
		hold_req = 1'b1;
		for (int rep = 0; rep < 3; rep++) begin
			for (int ch = 0; ch < NUM_LINKS; ch++)
				push_frame(ch, DIST_W'($urandom()), 1'b1);
			push_poll();
		end
		wait_idle();
		hold_req = 1'b0;

		// Narrow window, no idling on either side
		reg_write(int'(REG_MIN_DIST), CFG_DATA_W'($urandom_range(16'h1000, 16'h7000)));
		reg_write(int'(REG_OOR_DIST),
			CFG_DATA_W'(min_dist + DIST_W'($urandom_range(1, 16'h0800))));
		no_idle = 1'b1;
		push_random_items(40);
		push_poll();

		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || s_tvalid);
		drain_cyc = 0;
		while (packet_bytes_due.size() != 0 && drain_cyc < 5000) begin
			@(negedge clk);
			drain_cyc++;
		end
		repeat (20) @(negedge clk);
		if (packet_bytes_due.size() != 0)
			flag_mismatch("packet bytes never emitted", packet_bytes_due.size(), 0);
		if (mismatches == 0)
			$display("multi_rangefinder_frame_collector_core regression: pass");
		else
			$display("multi_rangefinder_frame_collector_core regression: fail");
		$finish;
	end

endmodule
